@@ src/gamepad_deadzone_and_edge_conditioner_macros.svh @@
// Assertion macros for the gamepad conditioner.
// Included by the top level; no other dependencies.
`ifndef GAMEPAD_DEADZONE_AND_EDGE_CONDITIONER_MACROS_SVH
`define GAMEPAD_DEADZONE_AND_EDGE_CONDITIONER_MACROS_SVH
`ifndef SYNTH
`define GDZ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GDZ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/gdz_pkg.sv @@
// Shared types and constants for the gamepad conditioner.
// No dependencies.
package gdz_pkg;

    localparam logic [2:0] CFG_LEFT_INNER  = 3'd0;
    localparam logic [2:0] CFG_LEFT_OUTER  = 3'd1;
    localparam logic [2:0] CFG_RIGHT_INNER = 3'd2;
    localparam logic [2:0] CFG_RIGHT_OUTER = 3'd3;
    localparam logic [2:0] CFG_LEFT_THR    = 3'd4;
    localparam logic [2:0] CFG_RIGHT_THR   = 3'd5;
    localparam logic [2:0] CFG_LEFT_FLIP   = 3'd6;
    localparam logic [2:0] CFG_RIGHT_FLIP  = 3'd7;

    localparam logic [15:0] LEFT_ACTIVE_MASK  = 16'h0040;
    localparam logic [15:0] RIGHT_ACTIVE_MASK = 16'h0080;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_MERGE
    } top_state_t;

    typedef enum logic [3:0] {
        L_IDLE,
        L_SQUARE,
        L_TEST,
        L_ROOT,
        L_QINIT,
        L_QDIV,
        L_MUL,
        L_PREP,
        L_SCALE,
        L_FIN
    } lane_state_t;

    typedef struct packed {
        logic load;
        logic present;
    } merge_ctrl_t;

endpackage

@@ src/gdz_ifs.sv @@
// Valid/ready channel interfaces for samples and results.
// No dependencies.
interface gdz_sample_if;
    logic               valid;
    logic               ready;
    logic               pad_present;
    logic [15:0]        button_bits;
    logic [7:0]         left_trigger_in;
    logic [7:0]         right_trigger_in;
    logic signed [15:0] left_x_in;
    logic signed [15:0] left_y_in;
    logic signed [15:0] right_x_in;
    logic signed [15:0] right_y_in;

    modport source (output valid, pad_present, button_bits, left_trigger_in,
                    right_trigger_in, left_x_in, left_y_in, right_x_in, right_y_in,
                    input ready);
    modport sink (input valid, pad_present, button_bits, left_trigger_in,
                  right_trigger_in, left_x_in, left_y_in, right_x_in, right_y_in,
                  output ready);
endinterface

interface gdz_result_if;
    logic               valid;
    logic               ready;
    logic               connected;
    logic [15:0]        held_buttons;
    logic [15:0]        pressed_buttons;
    logic [15:0]        released_buttons;
    logic [14:0]        left_trigger_out;
    logic [14:0]        right_trigger_out;
    logic signed [15:0] left_x_out;
    logic signed [15:0] left_y_out;
    logic signed [15:0] right_x_out;
    logic signed [15:0] right_y_out;

    modport source (output valid, connected, held_buttons, pressed_buttons,
                    released_buttons, left_trigger_out, right_trigger_out,
                    left_x_out, left_y_out, right_x_out, right_y_out,
                    input ready);
    modport sink (input valid, connected, held_buttons, pressed_buttons,
                  released_buttons, left_trigger_out, right_trigger_out,
                  left_x_out, left_y_out, right_x_out, right_y_out,
                  output ready);
endinterface

@@ src/gdz_trig_lane.v.sv @@
// Trigger lane: threshold and rescale to Q0.15 with a bit-serial divider.
// No package dependencies.
module gdz_trig_lane (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  raw,
    input  logic [7:0]  thr,
    output logic        busy,
    output logic [14:0] level
);
    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [22:0] num_reg;
    logic [7:0]  den_reg;
    logic [14:0] q_reg;
    logic [7:0]  diff;
    logic [7:0]  den;
    logic [22:0] num0;
    logic [22:0] dsh;

    assign diff = raw - thr;
    assign den  = 8'd255 - thr;
    // (diff * 32767) + den/2
    assign num0 = ({diff, 15'd0} - 23'(diff)) + 23'(den >> 1);
    assign dsh  = 23'(den_reg) << cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
            q_reg    <= 15'd0;
        end
        else if (start)
        begin
            q_reg    <= 15'd0;
            cnt_reg  <= 4'd14;
            busy_reg <= (raw > thr);
        end
        else if (busy_reg)
        begin
            if (num_reg >= dsh)
            begin
                q_reg[cnt_reg] <= 1'b1;
            end
            if (cnt_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num0;
            den_reg <= den;
        end
        else if (busy_reg && num_reg >= dsh)
        begin
            num_reg <= num_reg - dsh;
        end
    end

    assign busy  = busy_reg;
    assign level = q_reg;
endmodule

@@ src/gdz_stick_lane.sv @@
// Stick lane: clamp, flip, radial deadzone with iterative root and dividers.
// Depends on gdz_pkg.
module gdz_stick_lane #(
    parameter int FRACTION_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic               flip,
    input  logic [14:0]        inner,
    input  logic [14:0]        outer,
    output logic               busy,
    output logic signed [15:0] x_out,
    output logic signed [15:0] y_out
);
    import gdz_pkg::*;

    localparam int Q_W  = FRACTION_BITS + 1;
    localparam int P_W  = 15 + Q_W;
    localparam int N_W  = P_W + 17;
    localparam int D_W  = FRACTION_BITS + 17;
    localparam int QC_W = $clog2(FRACTION_BITS + 1);

    function automatic logic [14:0] abs_clamp(input logic signed [15:0] v);
        logic [15:0] neg;
        begin
            neg = 16'(-v);
            if (!v[15])
                abs_clamp = v[14:0];
            else if (v == -16'sd32768)
                abs_clamp = 15'h7FFF;
            else
                abs_clamp = neg[14:0];
        end
    endfunction

    lane_state_t      state_reg;
    logic [14:0]      ax_reg, ay_reg;
    logic             xneg_reg, yneg_reg;
    logic [29:0]      sx_reg, sy_reg, isq_reg;
    logic [47:0]      rad_reg, root_reg, bit_reg;
    logic [23:0]      qrem_reg;
    logic [22:0]      qdiv_reg;
    logic [Q_W-1:0]   q_reg;
    logic [QC_W-1:0]  qcnt_reg;
    logic [P_W-1:0]   px_reg, py_reg;
    logic [N_W-1:0]   nx_reg, ny_reg;
    logic [D_W-1:0]   d_reg;
    logic [3:0]       scnt_reg;
    logic             satx_reg, saty_reg;
    logic [14:0]      vx_reg, vy_reg;
    logic signed [15:0] x_out_reg, y_out_reg;

    logic [30:0]        ssum;
    logic [47:0]        trial;
    logic [23:0]        mag;
    logic signed [16:0] rem;
    logic [22:0]        dq, base;
    logic [23:0]        num;
    logic [24:0]        r2;
    logic [N_W-1:0]     dsh, dsat;
    logic [15:0]        vx_fin, vy_fin;

    assign ssum  = 31'(sx_reg) + 31'(sy_reg);
    assign trial = root_reg + bit_reg;
    assign mag   = root_reg[23:0];
    assign rem   = 17'sd32767 - $signed({2'b00, outer}) - $signed({2'b00, inner});
    assign dq    = {rem[14:0], 8'd0};
    assign base  = {inner, 8'd0};
    assign num   = (mag > 24'(base)) ? (mag - 24'(base)) : 24'd0;
    assign r2    = {qrem_reg, 1'b0};
    assign dsh   = N_W'(d_reg) << scnt_reg;
    assign dsat  = N_W'(d_reg) << 15;
    assign vx_fin = satx_reg ? 16'h7FFF : {1'b0, vx_reg};
    assign vy_fin = saty_reg ? 16'h7FFF : {1'b0, vy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            x_out_reg <= 16'sd0;
            y_out_reg <= 16'sd0;
        end
        else
        begin
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                        state_reg <= L_SQUARE;
                end
                L_SQUARE:
                    state_reg <= L_TEST;
                L_TEST:
                begin
                    if (ssum <= 31'(isq_reg))
                    begin
                        x_out_reg <= 16'sd0;
                        y_out_reg <= 16'sd0;
                        state_reg <= L_IDLE;
                    end
                    else
                        state_reg <= L_ROOT;
                end
                L_ROOT:
                begin
                    if (bit_reg == 48'd1)
                        state_reg <= L_QINIT;
                end
                L_QINIT:
                begin
                    if (rem <= 17'sd0 || num >= 24'(dq))
                        state_reg <= L_MUL;
                    else
                        state_reg <= L_QDIV;
                end
                L_QDIV:
                begin
                    if (qcnt_reg == QC_W'(1))
                        state_reg <= L_MUL;
                end
                L_MUL:
                    state_reg <= L_PREP;
                L_PREP:
                    state_reg <= L_SCALE;
                L_SCALE:
                begin
                    if (scnt_reg == 4'd0)
                        state_reg <= L_FIN;
                end
                L_FIN:
                begin
                    x_out_reg <= xneg_reg ? -$signed(vx_fin) : $signed(vx_fin);
                    y_out_reg <= yneg_reg ? -$signed(vy_fin) : $signed(vy_fin);
                    state_reg <= L_IDLE;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                ax_reg   <= abs_clamp(x_in);
                ay_reg   <= abs_clamp(y_in);
                xneg_reg <= x_in[15];
                yneg_reg <= y_in[15] ^ flip;
            end
            L_SQUARE:
            begin
                sx_reg  <= ax_reg * ax_reg;
                sy_reg  <= ay_reg * ay_reg;
                isq_reg <= inner * inner;
            end
            L_TEST:
            begin
                rad_reg  <= 48'(ssum) << 16;
                root_reg <= 48'd0;
                bit_reg  <= 48'd1 << 46;
            end
            L_ROOT:
            begin
                if (rad_reg >= trial)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            L_QINIT:
            begin
                // quotient is one when no range is left or the ratio reaches one
                q_reg    <= (rem <= 17'sd0 || num >= 24'(dq))
                            ? (Q_W'(1) << FRACTION_BITS) : '0;
                qrem_reg <= num;
                qdiv_reg <= dq;
                qcnt_reg <= QC_W'(FRACTION_BITS);
            end
            L_QDIV:
            begin
                if (r2 >= 25'(qdiv_reg))
                begin
                    qrem_reg <= 24'(r2 - 25'(qdiv_reg));
                    q_reg    <= {q_reg[Q_W-2:0], 1'b1};
                end
                else
                begin
                    qrem_reg <= r2[23:0];
                    q_reg    <= {q_reg[Q_W-2:0], 1'b0};
                end
                qcnt_reg <= qcnt_reg - QC_W'(1);
            end
            L_MUL:
            begin
                px_reg <= ax_reg * q_reg;
                py_reg <= ay_reg * q_reg;
            end
            L_PREP:
            begin
                // (a*q*32767*2 + mag*2^(FB-8)) / (mag*2^(FB-7)), rounded half up
                nx_reg <= ((N_W'(px_reg) << 16) - (N_W'(px_reg) << 1))
                          + (N_W'(mag) << (FRACTION_BITS - 8));
                ny_reg <= ((N_W'(py_reg) << 16) - (N_W'(py_reg) << 1))
                          + (N_W'(mag) << (FRACTION_BITS - 8));
                d_reg    <= D_W'(mag) << (FRACTION_BITS - 7);
                scnt_reg <= 4'd15;
            end
            L_SCALE:
            begin
                if (scnt_reg == 4'd15)
                begin
                    satx_reg <= (nx_reg >= dsat);
                    saty_reg <= (ny_reg >= dsat);
                    vx_reg   <= 15'd0;
                    vy_reg   <= 15'd0;
                end
                else
                begin
                    if (nx_reg >= dsh)
                    begin
                        nx_reg <= nx_reg - dsh;
                        vx_reg[scnt_reg] <= 1'b1;
                    end
                    if (ny_reg >= dsh)
                    begin
                        ny_reg <= ny_reg - dsh;
                        vy_reg[scnt_reg] <= 1'b1;
                    end
                end
                scnt_reg <= scnt_reg - 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy  = (state_reg != L_IDLE);
    assign x_out = x_out_reg;
    assign y_out = y_out_reg;
endmodule

@@ src/gdz_merge.sv @@
// Merge stage: combines lane results, button edges, holds the result register.
// Depends on gdz_pkg and gdz_result_if.
module gdz_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  gdz_pkg::merge_ctrl_t ctrl,
    input  logic [15:0]         buttons,
    input  logic [14:0]         trig_l,
    input  logic [14:0]         trig_r,
    input  logic signed [15:0]  lx,
    input  logic signed [15:0]  ly,
    input  logic signed [15:0]  rx,
    input  logic signed [15:0]  ry,
    output logic                free,
    gdz_result_if.source        result
);
    import gdz_pkg::*;

    logic               valid_reg, conn_reg;
    logic [15:0]        held_reg, pressed_reg, released_reg;
    logic [14:0]        tl_reg, tr_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic [15:0]        cur;

    assign cur = buttons
               | ((lx != 16'sd0 || ly != 16'sd0) ? LEFT_ACTIVE_MASK : 16'd0)
               | ((rx != 16'sd0 || ry != 16'sd0) ? RIGHT_ACTIVE_MASK : 16'd0);
    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            conn_reg     <= 1'b0;
            held_reg     <= 16'd0;
            pressed_reg  <= 16'd0;
            released_reg <= 16'd0;
            tl_reg       <= 15'd0;
            tr_reg       <= 15'd0;
            lx_reg       <= 16'sd0;
            ly_reg       <= 16'sd0;
            rx_reg       <= 16'sd0;
            ry_reg       <= 16'sd0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= 1'b1;
            conn_reg  <= ctrl.present;
            if (ctrl.present)
            begin
                held_reg     <= cur;
                pressed_reg  <= cur & ~held_reg;
                released_reg <= ~cur & held_reg;
                tl_reg       <= trig_l;
                tr_reg       <= trig_r;
                lx_reg       <= lx;
                ly_reg       <= ly;
                rx_reg       <= rx;
                ry_reg       <= ry;
            end
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign result.valid             = valid_reg;
    assign result.connected         = conn_reg;
    assign result.held_buttons      = held_reg;
    assign result.pressed_buttons   = pressed_reg;
    assign result.released_buttons  = released_reg;
    assign result.left_trigger_out  = tl_reg;
    assign result.right_trigger_out = tr_reg;
    assign result.left_x_out        = lx_reg;
    assign result.left_y_out        = ly_reg;
    assign result.right_x_out       = rx_reg;
    assign result.right_y_out       = ry_reg;
endmodule

@@ src/gamepad_deadzone_and_edge_conditioner.sv @@
// Gamepad sample conditioner: top level with config registers and control.
// Depends on gdz_pkg, gdz_ifs, the lanes, gdz_merge and the macros header.
//
// Usage:
//  - sample: one polled pad sample per transaction (valid/ready).
//  - result: one conditioned result per sample (valid/ready), held in a
//    result register so the next sample is taken while it waits.
//  - cfg_we/cfg_index/cfg_data: register writes, only while the block is idle.
//  - One sample is processed at a time. In the longest case for a present
//    pad the stick lanes run a 24-step square root, a FRACTION_BITS-step
//    deadzone quotient and a 16-step output scale divider. Triggers run in
//    parallel lanes (15 steps). Sticks inside the inner zone stop after the
//    zone test with zero output.
//  - An absent pad skips the lanes: control goes straight to the merge
//    state, and the result register loads once it is free.
//  - Reset clears all history to zero and loads the default zones.
//  - If the receiver stalls, the finished sample waits in the merge stage
//    until the result register frees up; sample.ready stays low meanwhile.
`include "gamepad_deadzone_and_edge_conditioner_macros.svh"
module gamepad_deadzone_and_edge_conditioner #(
    parameter int FRACTION_BITS = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    gdz_sample_if.sink    sample,
    gdz_result_if.source  result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [14:0]   cfg_data
);
    import gdz_pkg::*;

    // configuration registers
    logic [14:0] l_inner_reg, l_outer_reg, r_inner_reg, r_outer_reg;
    logic [7:0]  l_thr_reg, r_thr_reg;
    logic        l_flip_reg, r_flip_reg;

    top_state_t  state_reg, state_next;
    logic        present_reg;
    logic [15:0] buttons_reg;

    logic        accept, start, merge_free, any_busy;
    logic        tl_busy, tr_busy, sl_busy, sr_busy;
    logic [14:0] tl_level, tr_level;
    logic signed [15:0] lx, ly, rx, ry;
    merge_ctrl_t mctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_inner_reg <= 15'd7849;
            l_outer_reg <= 15'd0;
            r_inner_reg <= 15'd8689;
            r_outer_reg <= 15'd0;
            l_thr_reg   <= 8'd30;
            r_thr_reg   <= 8'd30;
            l_flip_reg  <= 1'b0;
            r_flip_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_INNER:  l_inner_reg <= cfg_data;
                CFG_LEFT_OUTER:  l_outer_reg <= cfg_data;
                CFG_RIGHT_INNER: r_inner_reg <= cfg_data;
                CFG_RIGHT_OUTER: r_outer_reg <= cfg_data;
                CFG_LEFT_THR:    l_thr_reg   <= cfg_data[7:0];
                CFG_RIGHT_THR:   r_thr_reg   <= cfg_data[7:0];
                CFG_LEFT_FLIP:   l_flip_reg  <= cfg_data[0];
                CFG_RIGHT_FLIP:  r_flip_reg  <= cfg_data[0];
                default:         l_flip_reg  <= l_flip_reg;
            endcase
        end
    end

    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    // lanes only run for a present pad; absent samples repeat history
    assign start        = accept && sample.pad_present;
    assign any_busy     = tl_busy || tr_busy || sl_busy || sr_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            present_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                present_reg <= sample.pad_present;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buttons_reg <= sample.button_bits;
    end

    always_comb
    begin
        state_next    = state_reg;
        mctrl.load    = 1'b0;
        mctrl.present = present_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = sample.pad_present ? ST_RUN : ST_MERGE;
            end
            ST_RUN:
            begin
                if (!any_busy)
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (merge_free)
                begin
                    mctrl.load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    gdz_trig_lane u_trig_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .raw   (sample.left_trigger_in),
        .thr   (l_thr_reg),
        .busy  (tl_busy),
        .level (tl_level)
    );

    gdz_trig_lane u_trig_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .raw   (sample.right_trigger_in),
        .thr   (r_thr_reg),
        .busy  (tr_busy),
        .level (tr_level)
    );

    gdz_stick_lane #(.FRACTION_BITS(FRACTION_BITS)) u_stick_l (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .x_in  (sample.left_x_in),
        .y_in  (sample.left_y_in),
        .flip  (l_flip_reg),
        .inner (l_inner_reg),
        .outer (l_outer_reg),
        .busy  (sl_busy),
        .x_out (lx),
        .y_out (ly)
    );

    gdz_stick_lane #(.FRACTION_BITS(FRACTION_BITS)) u_stick_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .x_in  (sample.right_x_in),
        .y_in  (sample.right_y_in),
        .flip  (r_flip_reg),
        .inner (r_inner_reg),
        .outer (r_outer_reg),
        .busy  (sr_busy),
        .x_out (rx),
        .y_out (ry)
    );

    gdz_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mctrl),
        .buttons (buttons_reg),
        .trig_l  (tl_level),
        .trig_r  (tr_level),
        .lx      (lx),
        .ly      (ly),
        .rx      (rx),
        .ry      (ry),
        .free    (merge_free),
        .result  (result)
    );

    // lanes are quiet whenever a new sample can be taken
    `GDZ_ASSERT_NOW(a_idle_lanes, clk, rst_n, state_reg == ST_IDLE, !any_busy)
    // an absent pad goes straight to the merge stage
    `GDZ_ASSERT_NEXT(a_absent_skip, clk, rst_n, accept && !sample.pad_present, state_reg == ST_MERGE)
    // a merge load always shows up as a valid result
    `GDZ_ASSERT_NEXT(a_load_valid, clk, rst_n, state_reg == ST_MERGE && merge_free, result.valid)
endmodule
